### hw/rtl/swat_pkg.sv
// Shared types, constants and microcode codes of the sliding window ack tracker.
package swat_pkg;

	localparam int WINDOW = 32;
	localparam int SEQ_W  = 32;
	localparam int MASK_W = 32;
	localparam int IDX_W  = $clog2(MASK_W);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int OPND_W = SEQ_W + 1;
	localparam int PC_W   = 3;

	localparam logic [MASK_W-1:0] KEEP_MASK = MASK_W'((64'd1 << WINDOW) - 64'd1);

	localparam logic [1:0] ACT_OBSERVE = 2'd0;
	localparam logic [1:0] ACT_MERGE   = 2'd1;
	localparam logic [1:0] ACT_QUERY   = 2'd2;

	localparam logic [1:0] OBS_NONE   = 2'd0;
	localparam logic [1:0] OBS_ALL    = 2'd1;
	localparam logic [1:0] OBS_MASKED = 2'd2;

	localparam logic [1:0] OPND_HOLD = 2'd0;
	localparam logic [1:0] OPND_BASE = 2'd1;
	localparam logic [1:0] OPND_INC  = 2'd2;

	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_LOAD = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;

	localparam logic [2:0] JC_NEXT      = 3'd0;
	localparam logic [2:0] JC_ALWAYS    = 3'd1;
	localparam logic [2:0] JC_DISPATCH  = 3'd2;
	localparam logic [2:0] JC_RNEW_ZERO = 3'd3;
	localparam logic [2:0] JC_CNT_MORE  = 3'd4;
	localparam logic [2:0] JC_OUT_BUSY  = 3'd5;

	localparam logic [PC_W-1:0] U_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] U_OBS   = 3'd1;
	localparam logic [PC_W-1:0] U_MRG0  = 3'd2;
	localparam logic [PC_W-1:0] U_MRGL  = 3'd3;
	localparam logic [PC_W-1:0] U_MRGN  = 3'd4;
	localparam logic [PC_W-1:0] U_QRY   = 3'd5;
	localparam logic [PC_W-1:0] U_SPARE = 3'd6;
	localparam logic [PC_W-1:0] U_DONE  = 3'd7;

	typedef struct packed {
		logic [1:0]        action;
		logic [SEQ_W-1:0]  sequence_req;
		logic [SEQ_W-1:0]  reported_newest;
		logic [MASK_W-1:0] reported_mask;
	} req_t;

	typedef struct packed {
		logic              confirmed;
		logic              expired;
		logic [SEQ_W-1:0]  newest_sequence;
		logic [MASK_W-1:0] received_mask;
	} rsp_t;

	typedef struct packed {
		logic [1:0]      obs;
		logic [1:0]      opnd;
		logic [1:0]      cnt;
		logic            qry;
		logic            out_en;
		logic [2:0]      jc;
		logic [PC_W-1:0] tgt;
	} ctrl_t;

	typedef struct packed {
		logic       accept;
		logic [1:0] action;
		logic       rnew_zero;
		logic       cnt_more;
		logic       out_busy;
	} stat_t;

endpackage

### hw/rtl/swat_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module swat_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  swat_pkg::stat_t stat,
	output swat_pkg::ctrl_t ctrl,
	output logic            idle
);
	import swat_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	logic [PC_W-1:0] pc_inc;
	logic [PC_W-1:0] dispatch;

	function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{obs: OBS_NONE, opnd: OPND_HOLD, cnt: CNT_HOLD, qry: 1'b0, out_en: 1'b0,
			jc: JC_ALWAYS, tgt: U_DONE};
		case (pc)
			U_IDLE: begin
				w.jc  = JC_DISPATCH;
				w.tgt = U_IDLE;
			end
			U_OBS: begin
				w.obs = OBS_ALL;
			end
			U_MRG0: begin
				w.opnd = OPND_BASE;
				w.cnt  = CNT_LOAD;
				w.jc   = JC_RNEW_ZERO;
			end
			U_MRGL: begin
				w.obs  = OBS_MASKED;
				w.opnd = OPND_INC;
				w.cnt  = CNT_DEC;
				w.jc   = JC_CNT_MORE;
				w.tgt  = U_MRGL;
			end
			U_MRGN: begin
				w.obs = OBS_ALL;
			end
			U_QRY: begin
				w.qry = 1'b1;
			end
			U_SPARE: begin
				w.jc = JC_ALWAYS;
			end
			U_DONE: begin
				w.out_en = 1'b1;
				w.jc     = JC_OUT_BUSY;
				w.tgt    = U_DONE;
			end
			default: begin
				w.jc  = JC_ALWAYS;
				w.tgt = U_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctrl   = rom(pc_q);
	assign idle   = (pc_q == U_IDLE);
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		case (stat.action)
			ACT_OBSERVE: dispatch = U_OBS;
			ACT_MERGE:   dispatch = U_MRG0;
			ACT_QUERY:   dispatch = U_QRY;
			default:     dispatch = U_DONE;
		endcase
	end

	always_comb begin
		case (ctrl.jc)
			JC_NEXT:      pc_next = pc_inc;
			JC_ALWAYS:    pc_next = ctrl.tgt;
			JC_DISPATCH:  pc_next = stat.accept ? dispatch : ctrl.tgt;
			JC_RNEW_ZERO: pc_next = stat.rnew_zero ? ctrl.tgt : pc_inc;
			JC_CNT_MORE:  pc_next = stat.cnt_more ? ctrl.tgt : pc_inc;
			JC_OUT_BUSY:  pc_next = stat.out_busy ? ctrl.tgt : pc_inc;
			default:      pc_next = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= U_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

### hw/rtl/swat_dp.sv
// Datapath: tracker state, operand and counter registers, observe and query logic.
module swat_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  swat_pkg::req_t          req_data,
	input  swat_pkg::ctrl_t         ctrl,
	output logic                    rnew_zero,
	output logic                    cnt_more,
	output swat_pkg::rsp_t          result
);
	import swat_pkg::*;

	req_t              in_q;
	logic [OPND_W-1:0] opnd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SEQ_W-1:0]  newest_q;
	logic [MASK_W-1:0] mask_q;
	logic              conf_q;
	logic              exp_q;

	logic [SEQ_W-1:0]  seq;
	logic [SEQ_W-1:0]  up;
	logic [SEQ_W-1:0]  dn;
	logic [IDX_W-1:0]  up_idx;
	logic [IDX_W-1:0]  dn_idx;
	logic [IDX_W-1:0]  bit_idx;
	logic              opnd_pos;
	logic              take;
	logic              obs_do;
	logic [SEQ_W-1:0]  newest_nx;
	logic [MASK_W-1:0] mask_nx;
	logic              conf_nx;
	logic              exp_nx;

	assign seq      = opnd_q[SEQ_W-1:0];
	assign up       = seq - newest_q;
	assign dn       = newest_q - seq;
	assign up_idx   = IDX_W'(up - SEQ_W'(1));
	assign dn_idx   = IDX_W'(dn - SEQ_W'(1));
	assign bit_idx  = IDX_W'(cnt_q - CNT_W'(1));
	assign opnd_pos = !opnd_q[OPND_W-1] && (seq != '0);
	assign take     = opnd_pos && in_q.reported_mask[bit_idx];
	assign obs_do   = (ctrl.obs == OBS_ALL) || ((ctrl.obs == OBS_MASKED) && take);

	assign rnew_zero = (in_q.reported_newest == '0);
	assign cnt_more  = (cnt_q != CNT_W'(1));

	always_comb begin
		newest_nx = newest_q;
		mask_nx   = mask_q;
		if (seq == '0) begin
			newest_nx = newest_q;
		end else if (newest_q == '0) begin
			newest_nx = seq;
			mask_nx   = '0;
		end else if (seq > newest_q) begin
			newest_nx = seq;
			if (up < SEQ_W'(WINDOW)) begin
				mask_nx = ((mask_q << IDX_W'(up)) | (MASK_W'(1) << up_idx)) & KEEP_MASK;
			end else if (up == SEQ_W'(WINDOW)) begin
				mask_nx = (MASK_W'(1) << IDX_W'(WINDOW - 1)) & KEEP_MASK;
			end else begin
				mask_nx = '0;
			end
		end else if ((seq < newest_q) && (dn <= SEQ_W'(WINDOW))) begin
			mask_nx = (mask_q | (MASK_W'(1) << dn_idx)) & KEEP_MASK;
		end
	end

	always_comb begin
		conf_nx = 1'b0;
		exp_nx  = 1'b0;
		if ((seq != '0) && (newest_q != '0)) begin
			if (seq == newest_q) begin
				conf_nx = 1'b1;
			end else if (seq < newest_q) begin
				if (dn > SEQ_W'(WINDOW)) begin
					exp_nx = 1'b1;
				end else begin
					conf_nx = mask_q[dn_idx];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			mask_q   <= '0;
		end else if (obs_do) begin
			newest_q <= newest_nx;
			mask_q   <= mask_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q   <= req_data;
			opnd_q <= {1'b0, req_data.sequence_req};
			conf_q <= 1'b0;
			exp_q  <= 1'b0;
		end else begin
			case (ctrl.opnd)
				OPND_BASE: opnd_q <= {1'b0, in_q.reported_newest} - OPND_W'(WINDOW);
				OPND_INC:  opnd_q <= opnd_q + OPND_W'(1);
				default:   opnd_q <= opnd_q;
			endcase
			if (ctrl.qry) begin
				conf_q <= conf_nx;
				exp_q  <= exp_nx;
			end
		end
		case (ctrl.cnt)
			CNT_LOAD: cnt_q <= CNT_W'(WINDOW);
			CNT_DEC:  cnt_q <= cnt_q - CNT_W'(1);
			default:  cnt_q <= cnt_q;
		endcase
	end

	assign result = '{confirmed: conf_q, expired: exp_q, newest_sequence: newest_q,
		received_mask: mask_q};

`ifndef NO_ASSERTIONS
	a_newest_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (newest_q >= $past(newest_q)))
		else $error("newest sequence moved backward");

	a_merge_loop_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cnt == CNT_DEC) |-> (cnt_q != '0))
		else $error("merge loop counter underflow");
`endif

endmodule

### hw/rtl/sliding_window_ack_tracker_top.sv
// Top level of the sliding window ack tracker: handshakes, sequencer, datapath, result register.
//
// One item is taken at a time; the block stalls its request side until the item's result
// has been placed in the result register, which holds it for the consumer while the next
// item is already accepted. An observe, a query and a merge with a zero reported newest
// each run their action's microcode step and then the done step, which loads the result
// register; an unused action goes straight to the done step. After the done step the
// sequencer returns to idle, where the next item is accepted. A merge steps the single
// observe unit through the microcode loop once per reported mask bit, oldest first,
// followed by the reported newest. A stalled result register holds the sequencer in the
// done step while it stays full.
module sliding_window_ack_tracker_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  swat_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output swat_pkg::rsp_t rsp_data
);
	import swat_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	rsp_t  result;
	logic  idle;
	logic  accept;
	logic  rnew_zero;
	logic  cnt_more;
	logic  out_busy;
	logic  out_load;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	assign req_stall = !idle;
	assign accept    = req_valid && idle;
	assign out_busy  = rsp_valid_q && rsp_stall;
	assign out_load  = ctrl.out_en && !out_busy;

	assign stat = '{accept: accept, action: req_data.action, rnew_zero: rnew_zero,
		cnt_more: cnt_more, out_busy: out_busy};

	swat_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.idle   (idle)
	);

	swat_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_data  (req_data),
		.ctrl      (ctrl),
		.rnew_zero (rnew_zero),
		.cnt_more  (cnt_more),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef NO_ASSERTIONS
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("item accepted without entering the program");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.confirmed && rsp_data.expired))
		else $error("result both confirmed and expired");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.out_en && out_busy) |=> (rsp_valid && $stable(rsp_data) && req_stall))
		else $error("result overwritten or block released while consumer stalls");
`endif

endmodule
